/* hw/rtl/mlps_pkg.sv */
package mlps_pkg;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned REG_W  = 16;
  localparam int unsigned CNT_W  = 16;
  localparam int unsigned ANG_W  = 32;
  localparam int unsigned CFG_IDX_W = 4;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_NONE     = 2'd0;
  localparam kind_t KIND_OPTIONS  = 2'd1;
  localparam kind_t KIND_POSITION = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_OPTION_PERIOD   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POSITION_PERIOD = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPLY_TIMEOUT   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ONLINE_TIMEOUT  = 4'd3;

  localparam logic [REG_W-1:0] OPTION_PERIOD_RST   = 16'd500;
  localparam logic [REG_W-1:0] POSITION_PERIOD_RST = 16'd50;
  localparam logic [REG_W-1:0] REPLY_TIMEOUT_RST   = 16'd100;
  localparam logic [REG_W-1:0] ONLINE_TIMEOUT_RST  = 16'd1500;

  localparam logic [TIME_W-1:0] REQUEST_TIME_RST =
    TIME_W'(0) - {{(TIME_W-REG_W){1'b0}}, OPTION_PERIOD_RST};
  localparam logic [TIME_W-1:0] POLL_TIME_RST =
    TIME_W'(0) - {{(TIME_W-REG_W){1'b0}}, POSITION_PERIOD_RST};

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef struct packed {
    logic [TIME_W-1:0] now_time;
    logic              frame_seen;
    logic              options_seen;
    logic              option_emm_bit;
    logic              option_loop_bit;
    logic              position_seen;
    logic [ANG_W-1:0]  position_word;
    logic              session_active;
    logic              tx_ready;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

  typedef struct packed {
    logic              send_options;
    logic              send_position;
    logic              online;
    logic              opts_known;
    logic              firmware_ok;
    logic              closed_loop;
    logic              command_allowed;
    logic              motion_allowed;
    logic [CNT_W-1:0]  option_timeouts;
    logic [CNT_W-1:0]  position_timeouts;
    logic [ANG_W-1:0]  angle_word;
    logic              angle_valid;
  } result_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v != CNT_MAX) ? v + CNT_W'(1) : v;
  endfunction

endpackage

/* hw/rtl/mlps_in_if.sv */
interface mlps_in_if;
  import mlps_pkg::*;

  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] now_time;
  logic              frame_seen;
  logic              options_seen;
  logic              option_emm_bit;
  logic              option_loop_bit;
  logic              position_seen;
  logic [ANG_W-1:0]  position_word;
  logic              session_active;
  logic              tx_ready;

  modport source (
    output valid, now_time, frame_seen, options_seen, option_emm_bit,
           option_loop_bit, position_seen, position_word, session_active, tx_ready,
    input  ready
  );

  modport sink (
    input  valid, now_time, frame_seen, options_seen, option_emm_bit,
           option_loop_bit, position_seen, position_word, session_active, tx_ready,
    output ready
  );
endinterface

/* hw/rtl/mlps_out_if.sv */
interface mlps_out_if;
  import mlps_pkg::*;

  logic             valid;
  logic             ready;
  logic             send_options;
  logic             send_position;
  logic             online;
  logic             opts_known;
  logic             firmware_ok;
  logic             closed_loop;
  logic             command_allowed;
  logic             motion_allowed;
  logic [CNT_W-1:0] option_timeouts;
  logic [CNT_W-1:0] position_timeouts;
  logic [ANG_W-1:0] angle_word;
  logic             angle_valid;

  modport source (
    output valid, send_options, send_position, online, opts_known, firmware_ok,
           closed_loop, command_allowed, motion_allowed, option_timeouts,
           position_timeouts, angle_word, angle_valid,
    input  ready
  );

  modport sink (
    input  valid, send_options, send_position, online, opts_known, firmware_ok,
           closed_loop, command_allowed, motion_allowed, option_timeouts,
           position_timeouts, angle_word, angle_valid,
    output ready
  );
endinterface

/* hw/rtl/mlps_front.sv */
module mlps_front (
  input  logic            clk,
  input  logic            rst_n,
  mlps_in_if.sink         in_ch,
  output mlps_pkg::head_t head,
  input  logic            pop
);
  import mlps_pkg::*;

  item_t      q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  logic       do_pop;
  item_t      in_item;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign do_pop      = pop && (cnt_r != 2'd0);

  always_comb begin
    in_item.now_time        = in_ch.now_time;
    in_item.frame_seen      = in_ch.frame_seen;
    in_item.options_seen    = in_ch.options_seen;
    in_item.option_emm_bit  = in_ch.option_emm_bit;
    in_item.option_loop_bit = in_ch.option_loop_bit;
    in_item.position_seen   = in_ch.position_seen;
    in_item.position_word   = in_ch.position_word;
    in_item.session_active  = in_ch.session_active;
    in_item.tx_ready        = in_ch.tx_ready;
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= in_item;
    end
  end

  assign head.valid = (cnt_r != 2'd0);
  assign head.item  = q_r[rd_ptr_r];

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count overflow");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd1) |-> (wr_ptr_r != rd_ptr_r)) else $error("queue pointers out of step");

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !head.valid) |=> $stable(rd_ptr_r)) else $error("pop from empty queue");

endmodule

/* hw/rtl/mlps_back.sv */
module mlps_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [mlps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mlps_pkg::REG_W-1:0]        cfg_wdata,
  input  mlps_pkg::head_t                   head,
  output logic                              pop,
  mlps_out_if.source                        out_ch
);
  import mlps_pkg::*;

  logic [REG_W-1:0]  opt_period_r, pos_period_r, reply_tmo_r, online_tmo_r;

  kind_t             pending_r, pending_nxt;
  logic [TIME_W-1:0] request_time_r, request_time_nxt;
  logic [TIME_W-1:0] poll_time_r, poll_time_nxt;
  logic [TIME_W-1:0] option_time_r, option_time_nxt;
  logic [TIME_W-1:0] reply_time_r, reply_time_nxt;
  logic              opts_valid_r, opts_valid_nxt;
  logic              firmware_r, firmware_nxt;
  logic              loop_r, loop_nxt;
  logic [ANG_W-1:0]  angle_r, angle_nxt;
  logic              angle_valid_r, angle_valid_nxt;
  logic [CNT_W-1:0]  opt_cnt_r, opt_cnt_nxt;
  logic [CNT_W-1:0]  pos_cnt_r, pos_cnt_nxt;

  logic              out_valid_r;
  result_t           res_r, res_nxt;
  logic              load;

  item_t             it;
  logic [TIME_W-1:0] age_req, age_opt, age_poll, age_reply;
  logic              send_opt, send_pos, online, cmd_ok;

  assign it   = head.item;
  assign load = head.valid && (!out_valid_r || out_ch.ready);
  assign pop  = load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      opt_period_r <= OPTION_PERIOD_RST;
      pos_period_r <= POSITION_PERIOD_RST;
      reply_tmo_r  <= REPLY_TIMEOUT_RST;
      online_tmo_r <= ONLINE_TIMEOUT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_OPTION_PERIOD:   opt_period_r <= cfg_wdata;
        REG_POSITION_PERIOD: pos_period_r <= cfg_wdata;
        REG_REPLY_TIMEOUT:   reply_tmo_r  <= cfg_wdata;
        REG_ONLINE_TIMEOUT:  online_tmo_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    pending_nxt      = pending_r;
    request_time_nxt = request_time_r;
    poll_time_nxt    = poll_time_r;
    option_time_nxt  = option_time_r;
    reply_time_nxt   = reply_time_r;
    opts_valid_nxt   = opts_valid_r;
    firmware_nxt     = firmware_r;
    loop_nxt         = loop_r;
    angle_nxt        = angle_r;
    angle_valid_nxt  = angle_valid_r;
    opt_cnt_nxt      = opt_cnt_r;
    pos_cnt_nxt      = pos_cnt_r;
    send_opt         = 1'b0;
    send_pos         = 1'b0;

    // drop an option query once a session runs
    if (it.session_active && pending_nxt == KIND_OPTIONS) begin
      pending_nxt = KIND_NONE;
    end
    if (it.frame_seen) begin
      reply_time_nxt = it.now_time;
    end
    if (it.options_seen) begin
      opts_valid_nxt  = 1'b1;
      firmware_nxt    = !it.option_emm_bit;
      loop_nxt        = it.option_loop_bit;
      option_time_nxt = it.now_time;
      if (pending_nxt == KIND_OPTIONS) begin
        pending_nxt = KIND_NONE;
      end
    end
    if (it.position_seen) begin
      angle_nxt       = it.position_word;
      angle_valid_nxt = 1'b1;
      if (pending_nxt == KIND_POSITION) begin
        pending_nxt = KIND_NONE;
      end
    end

    age_req   = it.now_time - request_time_r;
    age_opt   = it.now_time - option_time_nxt;
    age_poll  = it.now_time - poll_time_r;
    age_reply = it.now_time - reply_time_nxt;

    // expire a stale request
    if (pending_nxt != KIND_NONE &&
        age_req >= {{(TIME_W-REG_W){1'b0}}, reply_tmo_r}) begin
      if (pending_nxt == KIND_OPTIONS) begin
        opt_cnt_nxt = sat_inc(opt_cnt_r);
      end else begin
        pos_cnt_nxt = sat_inc(pos_cnt_r);
      end
      pending_nxt = KIND_NONE;
    end

    if (pending_nxt == KIND_NONE) begin
      if (!it.session_active && (!opts_valid_nxt ||
          age_opt >= {{(TIME_W-REG_W){1'b0}}, opt_period_r})) begin
        if (it.tx_ready) begin
          send_opt         = 1'b1;
          request_time_nxt = it.now_time;
          pending_nxt      = KIND_OPTIONS;
        end
      end else if (opts_valid_nxt &&
                   age_poll >= {{(TIME_W-REG_W){1'b0}}, pos_period_r}) begin
        if (it.tx_ready) begin
          send_pos         = 1'b1;
          request_time_nxt = it.now_time;
          poll_time_nxt    = it.now_time;
          pending_nxt      = KIND_POSITION;
        end
      end
    end

    online = opts_valid_nxt && (age_reply <= {{(TIME_W-REG_W){1'b0}}, online_tmo_r});
    cmd_ok = (online || it.session_active) && opts_valid_nxt && firmware_nxt;

    res_nxt.send_options      = send_opt;
    res_nxt.send_position     = send_pos;
    res_nxt.online            = online;
    res_nxt.opts_known        = opts_valid_nxt;
    res_nxt.firmware_ok       = firmware_nxt;
    res_nxt.closed_loop       = loop_nxt;
    res_nxt.command_allowed   = cmd_ok;
    res_nxt.motion_allowed    = cmd_ok && loop_nxt;
    res_nxt.option_timeouts   = opt_cnt_nxt;
    res_nxt.position_timeouts = pos_cnt_nxt;
    res_nxt.angle_word        = angle_nxt;
    res_nxt.angle_valid       = angle_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r      <= KIND_NONE;
      request_time_r <= REQUEST_TIME_RST;
      poll_time_r    <= POLL_TIME_RST;
      option_time_r  <= '0;
      reply_time_r   <= '0;
      opts_valid_r   <= 1'b0;
      firmware_r     <= 1'b0;
      loop_r         <= 1'b0;
      angle_r        <= '0;
      angle_valid_r  <= 1'b0;
      opt_cnt_r      <= '0;
      pos_cnt_r      <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (load) begin
        pending_r      <= pending_nxt;
        request_time_r <= request_time_nxt;
        poll_time_r    <= poll_time_nxt;
        option_time_r  <= option_time_nxt;
        reply_time_r   <= reply_time_nxt;
        opts_valid_r   <= opts_valid_nxt;
        firmware_r     <= firmware_nxt;
        loop_r         <= loop_nxt;
        angle_r        <= angle_nxt;
        angle_valid_r  <= angle_valid_nxt;
        opt_cnt_r      <= opt_cnt_nxt;
        pos_cnt_r      <= pos_cnt_nxt;
        out_valid_r    <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.send_options      = res_r.send_options;
  assign out_ch.send_position     = res_r.send_position;
  assign out_ch.online            = res_r.online;
  assign out_ch.opts_known        = res_r.opts_known;
  assign out_ch.firmware_ok       = res_r.firmware_ok;
  assign out_ch.closed_loop       = res_r.closed_loop;
  assign out_ch.command_allowed   = res_r.command_allowed;
  assign out_ch.motion_allowed    = res_r.motion_allowed;
  assign out_ch.option_timeouts   = res_r.option_timeouts;
  assign out_ch.position_timeouts = res_r.position_timeouts;
  assign out_ch.angle_word        = res_r.angle_word;
  assign out_ch.angle_valid       = res_r.angle_valid;

  a_no_code3: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r != 2'd3) else $error("unused pending code reached");

  a_opt_sent: assert property (@(posedge clk) disable iff (!rst_n)
    (load && send_opt) |=> (pending_r == KIND_OPTIONS && res_r.send_options))
    else $error("option query sent without pending slot");

  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(res_r.send_options && res_r.send_position))
    else $error("two requests in one beat");

  a_cnt_mono: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (opt_cnt_r >= $past(opt_cnt_r) && pos_cnt_r >= $past(pos_cnt_r)))
    else $error("timeout count went down");

endmodule

/* hw/rtl/motor_link_poll_scheduler.sv */
// An accepted beat is written into the queue, then loaded into the result register
// and offered on the result channel. Throughput: one beat per cycle unless the
// result channel stalls; the back end updates its state whenever it loads a beat.
// A two-entry queue decouples input acceptance from result stalls.
// Reset (rst_n low, synchronous) restores register defaults and clears state.
module motor_link_poll_scheduler (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [mlps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mlps_pkg::REG_W-1:0]     cfg_wdata,
  mlps_in_if.sink                        in_ch,
  mlps_out_if.source                     out_ch
);
  import mlps_pkg::*;

  head_t head;
  logic  pop;

  mlps_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .head  (head),
    .pop   (pop)
  );

  mlps_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .head      (head),
    .pop       (pop),
    .out_ch    (out_ch)
  );

endmodule
